// ===== src/erc_pkg.sv =====
// Package for the extent release coalescer: payload words, status codes, commands.
// No dependencies.
package erc_pkg;

  localparam int AllocEntriesDef = 16;
  localparam int FreeEntriesDef  = 16;
  localparam int AddrBitsDef     = 16;
  localparam int CfgIdxBits      = 1;
  localparam int CfgDataBits     = 16;

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_RECORD  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOJOB   = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_BADLEN  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic [CfgIdxBits-1:0] REG_REGION_START  = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_REGION_LENGTH = 1'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  job_id;
    logic [15:0] base_addr;
    logic [15:0] extent_len;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] freed_start;
    logic [15:0] freed_len;
    logic [4:0]  free_count;
  } out_word_t;

endpackage

// ===== src/extent_release_coalescer_unit.sv =====
// Top level of the extent release coalescer: sequencer walking both extent tables.
// Depends on erc_pkg.
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid_i/in_stall_o | erc_pkg::in_word_t
//  out     | out       | out_valid_o/out_stall_i | erc_pkg::out_word_t
//  cfg     | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// Each item walks the extent tables entry by entry: a record scans then shifts the
// allocation table; a release scans the allocation table, compacts it, scans the free
// table and then inserts into it, merges with a neighbour or compacts it after a merge.
// Init reloads the free table from the region registers. One compare/shift datapath serves all.
// Reset leaves one free extent of the reset region. No item is taken until the
// previous result has been taken from the output register.
module extent_release_coalescer_unit #(
  parameter int ALLOC_ENTRIES = erc_pkg::AllocEntriesDef,
  parameter int FREE_ENTRIES  = erc_pkg::FreeEntriesDef,
  parameter int ADDR_BITS     = erc_pkg::AddrBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  erc_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output erc_pkg::out_word_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [erc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [erc_pkg::CfgDataBits-1:0] cfg_data_i
);

  localparam int AW = $clog2(ALLOC_ENTRIES);
  localparam int FW = $clog2(FREE_ENTRIES);
  localparam int AC = $clog2(ALLOC_ENTRIES + 1);
  localparam int FC = $clog2(FREE_ENTRIES + 1);
  localparam logic [ADDR_BITS:0] AddrMask = {1'b0, {ADDR_BITS{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_REC_SCAN, S_REC_SHIFT, S_REL_SCAN, S_REL_SHIFT,
    S_FREE_SCAN, S_FREE_DECIDE, S_FREE_INS, S_FREE_DEL, S_DONE
  } state_e;

  state_e state_q;
  logic [15:0] reg_start_q, reg_len_q;
  logic [AC-1:0] na_q;
  logic [FC-1:0] nf_q;
  logic [AC-1:0] ai_q;
  logic [FC-1:0] fi_q;
  erc_pkg::in_word_t in_q;
  logic [ADDR_BITS-1:0] s_q, l_q;
  logic [2:0] st_q;
  logic out_valid_q;
  erc_pkg::out_word_t out_q;

  logic [7:0]           a_job   [ALLOC_ENTRIES];
  logic [ADDR_BITS-1:0] a_start [ALLOC_ENTRIES];
  logic [ADDR_BITS-1:0] a_len   [ALLOC_ENTRIES];
  logic [ADDR_BITS-1:0] f_start [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] f_len   [FREE_ENTRIES];

  logic [AW-1:0] ai;
  logic [FW-1:0] fi, fim1;
  logic [ADDR_BITS:0] end_w, pend_w, cur_s, sum3;
  logic has_prev, has_cur, touch_prev, touch_cur;
  logic [ADDR_BITS-1:0] in_s, in_l;

  assign ai   = ai_q[AW-1:0];
  assign fi   = fi_q[FW-1:0];
  assign fim1 = FW'(fi_q - FC'(1));
  assign in_s = ADDR_BITS'(in_data_i.base_addr);
  assign in_l = ADDR_BITS'(in_data_i.extent_len);
  assign end_w  = {1'b0, s_q} + {1'b0, l_q};
  assign has_prev = fi_q != '0;
  assign has_cur  = fi_q < nf_q;
  assign pend_w = {1'b0, f_start[fim1]} + {1'b0, f_len[fim1]};
  assign cur_s  = {1'b0, f_start[fi]};
  assign touch_prev = has_prev && pend_w == {1'b0, s_q};
  assign touch_cur  = has_cur && cur_s == end_w;
  // merged length: prev (if touching) + released + cur (if touching)
  assign sum3 = (touch_prev ? {1'b0, f_len[fim1]} : '0) + {1'b0, l_q}
              + (touch_cur ? {1'b0, f_len[fi]} : '0);

  assign in_stall_o  = state_q != S_IDLE || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      reg_start_q <= '0;
      reg_len_q   <= 16'hFFFF;
      na_q        <= '0;
      nf_q        <= FC'(1);
      out_valid_q <= 1'b0;
      f_start[0]  <= '0;
      f_len[0]    <= ADDR_BITS'(16'hFFFF);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          erc_pkg::REG_REGION_START:  reg_start_q <= cfg_data_i;
          erc_pkg::REG_REGION_LENGTH: reg_len_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            in_q <= in_data_i;
            s_q  <= in_s;
            l_q  <= in_l;
            st_q <= erc_pkg::ST_OK;
            ai_q <= '0;
            fi_q <= '0;
            unique case (in_data_i.cmd)
              erc_pkg::CMD_INIT: begin
                na_q <= '0;
                if (ADDR_BITS'(reg_len_q) != '0) begin
                  nf_q <= FC'(1);
                  f_start[0] <= ADDR_BITS'(reg_start_q);
                  f_len[0]   <= ADDR_BITS'(reg_len_q);
                end else nf_q <= '0;
                state_q <= S_DONE;
              end
              erc_pkg::CMD_RECORD: begin
                if (in_l == '0) begin
                  st_q <= erc_pkg::ST_BADLEN;
                  state_q <= S_DONE;
                end else if (na_q == AC'(ALLOC_ENTRIES)) begin
                  st_q <= erc_pkg::ST_FULL;
                  state_q <= S_DONE;
                end else state_q <= S_REC_SCAN;
              end
              erc_pkg::CMD_RELEASE: state_q <= S_REL_SCAN;
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_REC_SCAN: begin
          if (ai_q < na_q && a_start[ai] < s_q) ai_q <= ai_q + AC'(1);
          else begin
            fi_q    <= FC'(0);
            ai_q    <= na_q; // shift from top down to insertion point
            s_q     <= s_q;
            in_q.job_id <= in_q.job_id;
            // remember insertion point in out_q.freed_start; the ai_q walk stops there
            state_q <= S_REC_SHIFT;
            l_q     <= l_q;
            out_q.freed_start <= 16'(ai_q);
          end
        end
        S_REC_SHIFT: begin
          if (ai_q > AC'(out_q.freed_start)) begin
            a_job[ai]   <= a_job[AW'(ai_q - AC'(1))];
            a_start[ai] <= a_start[AW'(ai_q - AC'(1))];
            a_len[ai]   <= a_len[AW'(ai_q - AC'(1))];
            ai_q <= ai_q - AC'(1);
          end else begin
            a_job[ai]   <= in_q.job_id;
            a_start[ai] <= s_q;
            a_len[ai]   <= l_q;
            na_q <= na_q + AC'(1);
            state_q <= S_DONE;
          end
        end
        S_REL_SCAN: begin
          if (ai_q >= na_q) begin
            st_q <= erc_pkg::ST_NOJOB;
            state_q <= S_DONE;
          end else if (a_job[ai] == in_q.job_id) begin
            s_q <= a_start[ai];
            l_q <= a_len[ai];
            state_q <= S_REL_SHIFT;
          end else ai_q <= ai_q + AC'(1);
        end
        S_REL_SHIFT: begin
          if (ai_q + AC'(1) < na_q) begin
            a_job[ai]   <= a_job[AW'(ai_q + AC'(1))];
            a_start[ai] <= a_start[AW'(ai_q + AC'(1))];
            a_len[ai]   <= a_len[AW'(ai_q + AC'(1))];
            ai_q <= ai_q + AC'(1);
          end else begin
            na_q <= na_q - AC'(1);
            state_q <= S_FREE_SCAN;
          end
        end
        S_FREE_SCAN: begin
          if (fi_q < nf_q && cur_s < end_w) fi_q <= fi_q + FC'(1);
          else state_q <= S_FREE_DECIDE;
        end
        S_FREE_DECIDE: begin
          if (has_prev && pend_w > {1'b0, s_q}) begin
            st_q <= erc_pkg::ST_OVERLAP;
            state_q <= S_DONE;
          end else if (touch_prev || touch_cur) begin
            if (sum3 > AddrMask) begin
              st_q <= erc_pkg::ST_OVERLAP;
              state_q <= S_DONE;
            end else if (touch_prev) begin
              f_len[fim1] <= sum3[ADDR_BITS-1:0];
              state_q <= touch_cur ? S_FREE_DEL : S_DONE;
            end else begin
              f_start[fi] <= s_q;
              f_len[fi]   <= sum3[ADDR_BITS-1:0];
              state_q <= S_DONE;
            end
          end else if (nf_q == FC'(FREE_ENTRIES)) begin
            st_q <= erc_pkg::ST_FULL;
            state_q <= S_DONE;
          end else begin
            out_q.freed_start <= 16'(fi_q);
            fi_q <= nf_q;
            state_q <= S_FREE_INS;
          end
        end
        S_FREE_INS: begin
          if (fi_q > FC'(out_q.freed_start)) begin
            f_start[fi] <= f_start[fim1];
            f_len[fi]   <= f_len[fim1];
            fi_q <= fi_q - FC'(1);
          end else begin
            f_start[fi] <= s_q;
            f_len[fi]   <= l_q;
            nf_q <= nf_q + FC'(1);
            state_q <= S_DONE;
          end
        end
        S_FREE_DEL: begin
          if (fi_q + FC'(1) < nf_q) begin
            f_start[fi] <= f_start[FW'(fi_q + FC'(1))];
            f_len[fi]   <= f_len[FW'(fi_q + FC'(1))];
            fi_q <= fi_q + FC'(1);
          end else begin
            nf_q <= nf_q - FC'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          out_q.status <= st_q;
          out_q.free_count <= 5'(nf_q);
          if (st_q == erc_pkg::ST_OK && in_q.cmd == erc_pkg::CMD_RELEASE) begin
            out_q.freed_start <= 16'(s_q);
            out_q.freed_len   <= 16'(l_q);
          end else begin
            out_q.freed_start <= '0;
            out_q.freed_len   <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
